FILE: rtl/cfla_pkg.sv
// Shared constants, types and helpers for the chunked free-list block allocator.
`default_nettype none
package cfla_pkg;

    localparam int MAX_CHUNKS       = 8;
    localparam int CHUNK_W          = 3;
    localparam int OPEN_W           = 4;
    localparam int BLOCKS_PER_CHUNK = 256;
    localparam int BLOCK_W          = 8;
    localparam int COUNT_W          = 9;
    localparam int ADDR_W           = CHUNK_W + BLOCK_W;
    localparam int MEM_DEPTH        = MAX_CHUNKS * BLOCKS_PER_CHUNK;
    localparam int BB_W             = 17;
    localparam int OFFSET_W         = 24;
    localparam int PROD_W           = BLOCK_W + BB_W;
    localparam int STATUS_W         = 2;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = 1;
    localparam int QCNT_W           = 2;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_FIELDS_W     = CHUNK_W + BLOCK_W + OFFSET_W + COUNT_W;
    localparam int OUT_TDATA_W      = 48;

    localparam logic [BB_W-1:0] BLOCK_BYTES_RST = BB_W'(64);

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_ALLOC    = 2'd0;
    localparam t_status ST_OOM      = 2'd1;
    localparam t_status ST_FREED    = 2'd2;
    localparam t_status ST_BAD_FREE = 2'd3;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [CHUNK_W-1:0]   chunk;
        logic [BLOCK_W-1:0]   block;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef struct packed {
        t_status              status;
        logic [CHUNK_W-1:0]   chunk;
        logic [BLOCK_W-1:0]   block;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   count;
    } t_result;

    // Reset link of a block: 1-based next block, 0 ends the list.
    function automatic logic [COUNT_W-1:0] init_link(input logic [BLOCK_W-1:0] b);
        logic [COUNT_W-1:0] r;
        r = '0;
        if ({1'b0, b} < COUNT_W'(BLOCKS_PER_CHUNK - 1)) begin
            r = {1'b0, b} + COUNT_W'(2);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cfla_front.sv
// Front end: accepts request items, decodes them and queues them for the back end.
`default_nettype none
module cfla_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_init_done,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [cfla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // free_chunk, free_block
    input  wire                                s_axis_tuser,  // opcode
    input  wire                                i_pop,
    output cfla_pkg::t_cmd_q                   o_head
);
    import cfla_pkg::*;

    t_cmd               cmd_in;
    logic               push;
    t_cmd               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    always_comb begin
        cmd_in.kind  = t_cmd_kind'(s_axis_tuser);
        cmd_in.chunk = s_axis_tdata[CHUNK_W-1:0];
        cmd_in.block = s_axis_tdata[CHUNK_W+BLOCK_W-1:CHUNK_W];
    end

    assign s_axis_tready = i_init_done && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/cfla_back.sv
// Back end: chunk bookkeeping, link memory, configuration register and result register.
`default_nettype none
module cfla_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  cfla_pkg::t_cmd_q             i_head,
    output logic                         o_pop,
    output logic                         o_init_done,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [cfla_pkg::BB_W-1:0]    i_cfg_data,
    output logic                         o_res_valid,
    input  wire                          i_res_ready,
    output cfla_pkg::t_result            o_res
);
    import cfla_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_init_addr;
    logic [COUNT_W-1:0]   r_head  [MAX_CHUNKS];
    logic [COUNT_W-1:0]   r_avail [MAX_CHUNKS];
    logic [OPEN_W-1:0]    r_open;
    logic [CHUNK_W-1:0]   r_active_chunk;
    logic                 r_cur_valid;
    logic [CHUNK_W-1:0]   r_sel_chunk;
    logic [BLOCK_W-1:0]   r_sel_blk;
    logic [COUNT_W-1:0]   r_sel_avail;
    logic [BB_W-1:0]      r_block_bytes;
    logic [COUNT_W-1:0]   mem [MEM_DEPTH];
    logic [COUNT_W-1:0]   r_rd_data;
    logic                 r_o_valid;
    t_result              r_o_res;

    logic [MAX_CHUNKS-1:0] has_free;
    logic                  out_free;
    logic                  cur_ok;
    logic                  found;
    logic [CHUNK_W-1:0]    found_chunk;
    logic                  can_open;
    logic                  alloc_take;
    logic                  alloc_opens;
    logic [CHUNK_W-1:0]    alloc_chunk;
    t_cmd                  cmd;
    logic [CHUNK_W-1:0]    tgt;
    logic [COUNT_W-1:0]    tgt_head;
    logic [COUNT_W-1:0]    tgt_avail;
    logic [COUNT_W-1:0]    head_m1;
    logic                  free_ok;
    logic [COUNT_W-1:0]    free_avail;
    logic [COUNT_W-1:0]    next_head;
    logic [PROD_W-1:0]     prod;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_W-1:0]    mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  res_load;
    t_result               n_res;

    assign cmd         = i_head.cmd;
    assign out_free    = !r_o_valid || i_res_ready;
    assign o_init_done = (r_state != S_INIT);
    assign o_pop       = (r_state == S_IDLE) && i_head.valid && out_free;

    always_comb begin
        for (int c = 0; c < MAX_CHUNKS; c++) begin
            has_free[c] = (r_avail[c] != '0) && (r_head[c] != '0);
        end
    end

    always_comb begin
        found       = 1'b0;
        found_chunk = '0;
        for (int c = 0; c < MAX_CHUNKS; c++) begin
            if (!found && (OPEN_W'(c) < r_open) && has_free[c]) begin
                found       = 1'b1;
                found_chunk = CHUNK_W'(c);
            end
        end
    end

    always_comb begin
        cur_ok      = r_cur_valid && ({1'b0, r_active_chunk} < r_open) &&
                      has_free[r_active_chunk];
        can_open    = r_open < OPEN_W'(MAX_CHUNKS);
        alloc_take  = 1'b0;
        alloc_opens = 1'b0;
        alloc_chunk = '0;
        if (cur_ok) begin
            alloc_take  = 1'b1;
            alloc_chunk = r_active_chunk;
        end else if (found) begin
            alloc_take  = 1'b1;
            alloc_chunk = found_chunk;
        end else if (can_open) begin
            alloc_opens = 1'b1;
            alloc_chunk = r_open[CHUNK_W-1:0];
            alloc_take  = has_free[r_open[CHUNK_W-1:0]];
        end
    end

    always_comb begin
        tgt        = (cmd.kind == CMD_ALLOC) ? alloc_chunk : cmd.chunk;
        tgt_head   = r_head[tgt];
        tgt_avail  = r_avail[tgt];
        head_m1    = tgt_head - 1'b1;
        free_ok    = ({1'b0, cmd.chunk} < r_open) &&
                     ({1'b0, cmd.block} < COUNT_W'(BLOCKS_PER_CHUNK));
        free_avail = (tgt_avail < COUNT_W'(BLOCKS_PER_CHUNK)) ? tgt_avail + 1'b1 : tgt_avail;
        next_head  = (r_rd_data <= COUNT_W'(BLOCKS_PER_CHUNK)) ? r_rd_data : '0;
        prod       = PROD_W'(r_sel_blk) * PROD_W'(r_block_bytes);
    end

    always_comb begin
        res_load = 1'b0;
        n_res    = '0;
        if (r_state == S_READ) begin
            res_load     = out_free;
            n_res.status = ST_ALLOC;
            n_res.chunk  = r_sel_chunk;
            n_res.block  = r_sel_blk;
            n_res.offset = prod[OFFSET_W-1:0];
            n_res.count  = r_sel_avail;
        end else if (o_pop) begin
            if (cmd.kind == CMD_ALLOC) begin
                res_load     = !alloc_take;
                n_res.status = ST_OOM;
            end else begin
                res_load = 1'b1;
                if (free_ok) begin
                    n_res.status = ST_FREED;
                    n_res.count  = free_avail;
                end else begin
                    n_res.status = ST_BAD_FREE;
                end
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {cmd.chunk, cmd.block};
        mem_wdata = tgt_head;
        if (r_state == S_INIT) begin
            mem_we    = 1'b1;
            mem_waddr = r_init_addr;
            mem_wdata = init_link(r_init_addr[BLOCK_W-1:0]);
        end else if (o_pop && (cmd.kind == CMD_FREE) && free_ok) begin
            mem_we = 1'b1;
        end
        mem_re    = o_pop && (cmd.kind == CMD_ALLOC) && alloc_take;
        mem_raddr = {alloc_chunk, head_m1[BLOCK_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (i_cfg_valid) begin
            r_block_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            for (int c = 0; c < MAX_CHUNKS; c++) begin
                r_head[c]  <= COUNT_W'(1);
                r_avail[c] <= COUNT_W'(BLOCKS_PER_CHUNK);
            end
            r_open         <= '0;
            r_active_chunk <= '0;
            r_cur_valid    <= 1'b0;
            r_sel_chunk    <= '0;
            r_sel_blk      <= '0;
            r_sel_avail    <= '0;
            r_o_valid      <= 1'b0;
            r_o_res        <= '0;
        end else begin
            if (res_load) begin
                r_o_valid <= 1'b1;
                r_o_res   <= n_res;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + 1'b1;
                    if (r_init_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        if (cmd.kind == CMD_ALLOC) begin
                            if (alloc_opens) begin
                                r_open <= r_open + 1'b1;
                            end
                            if (alloc_take) begin
                                r_avail[alloc_chunk] <= tgt_avail - 1'b1;
                                r_sel_avail          <= tgt_avail - 1'b1;
                                r_sel_chunk          <= alloc_chunk;
                                r_sel_blk            <= head_m1[BLOCK_W-1:0];
                                r_active_chunk       <= alloc_chunk;
                                r_cur_valid          <= 1'b1;
                                r_state              <= S_READ;
                            end
                        end else if (free_ok) begin
                            r_head[cmd.chunk]  <= {1'b0, cmd.block} + 1'b1;
                            r_avail[cmd.chunk] <= free_avail;
                            if (free_avail == COUNT_W'(BLOCKS_PER_CHUNK)) begin
                                r_active_chunk <= cmd.chunk;
                                r_cur_valid    <= 1'b1;
                            end
                        end
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_head[r_sel_chunk] <= next_head;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

    a_cur_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> ({1'b0, r_active_chunk} < r_open))
        else $error("current chunk not open");

    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_W'(MAX_CHUNKS))
        else $error("open chunk count out of range");

    a_read_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && $past(r_state) != S_READ) |-> $past(o_pop))
        else $error("link read without a popped item");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_res.status == ST_ALLOC) |->
            (r_o_res.count < COUNT_W'(BLOCKS_PER_CHUNK)))
        else $error("allocated chunk reports full free count");

endmodule
`default_nettype wire

FILE: rtl/chunked_free_list_block_allocator.sv
// Top level of the chunked free-list block allocator.
// Requests arrive on the s_axis channel: tuser is the opcode (0 allocate, 1 free),
// tdata carries the chunk and block of a free. Each request yields exactly one
// result item on m_axis: tuser is the status, tdata the allocated chunk, block,
// byte offset and the free count of the chunk that was touched.
// The block size for the byte offset is written on the cfg channel, always ready;
// the user must write it only while the block is idle; the block itself does not enforce this.
// After reset the link memory is initialized by a sweep over every entry; s_axis_tready
// stays low until it is done. Requests pass through a two-item queue to the engine.
// A free is popped from the queue and its result loaded into the result register together;
// an allocate first waits in the S_READ state for the registered read of the link memory
// at the chunk's list head, and its result is loaded from that state.
// When m_axis_tready is low the result register holds, the engine stops, and the
// queue keeps taking requests until it is full.
`default_nettype none
module chunked_free_list_block_allocator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [cfla_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // free_chunk, free_block
    input  wire                                 s_axis_tuser,  // opcode
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // alloc_chunk, alloc_block, byte_offset, chunk_free_count
    output logic [cfla_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [cfla_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [cfla_pkg::BB_W-1:0]           i_cfg_data
);
    import cfla_pkg::*;

    t_cmd_q   head;
    logic     pop;
    logic     init_done;
    t_result  res;

    cfla_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_init_done   (init_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (pop),
        .o_head        (head)
    );

    cfla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_init_done (init_done),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                           res.count, res.offset, res.block, res.chunk};

endmodule
`default_nettype wire

FILE: tb/sv/chunked_free_list_block_allocator_tb.sv
// Testbench for the chunked free-list block allocator: self-checking, directed and random traffic.
`timescale 1ns / 1ps

module chunked_free_list_block_allocator_tb;
    import cfla_pkg::*;

    class pool_tracker;
        logic [COUNT_W-1:0] link_mem [MAX_CHUNKS][BLOCKS_PER_CHUNK+1];
        logic [COUNT_W-1:0] list_head [MAX_CHUNKS];
        logic [COUNT_W-1:0] free_cnt [MAX_CHUNKS];
        int                 open_cnt;
        logic [CHUNK_W-1:0] active_chunk;
        logic               cur_ok;
        logic [BB_W-1:0]    unit_bytes;
        t_result            pending_replies [$];
        int                 mismatches;

        function new();
            for (int c = 0; c < MAX_CHUNKS; c++) begin
                for (int i = 0; i < BLOCKS_PER_CHUNK; i++) begin
                    link_mem[c][i] = COUNT_W'(i + 1);
                end
                link_mem[c][BLOCKS_PER_CHUNK] = '0;
                list_head[c] = COUNT_W'(1);
                free_cnt[c] = COUNT_W'(BLOCKS_PER_CHUNK);
            end
            open_cnt = 0;
            active_chunk = '0;
            cur_ok = 1'b0;
            unit_bytes = BLOCK_BYTES_RST;
            mismatches = 0;
        endfunction

        function bit has_free(int c);
            return free_cnt[c] != 0 && list_head[c] != 0 &&
                   int'(list_head[c]) <= BLOCKS_PER_CHUNK;
        endfunction

        function t_result pop_block(int c);
            t_result r;
            int      idx;
            int      nxt;
            idx = int'(list_head[c]);
            nxt = int'(link_mem[c][idx]);
            list_head[c] = (nxt <= BLOCKS_PER_CHUNK) ? COUNT_W'(nxt) : '0;
            free_cnt[c] = free_cnt[c] - COUNT_W'(1);
            active_chunk = CHUNK_W'(c);
            cur_ok = 1'b1;
            r.status = ST_ALLOC;
            r.chunk = CHUNK_W'(c);
            r.block = BLOCK_W'(idx - 1);
            r.offset = OFFSET_W'(longint'(idx - 1) * longint'(unit_bytes));
            r.count = free_cnt[c];
            return r;
        endfunction

        function t_result note_request(t_cmd cmd);
            t_result r;
            int      fc;
            int      idx;
            bit      found;
            r = '0;
            found = 1'b0;
            if (cmd.kind == CMD_ALLOC) begin
                if (cur_ok && int'(active_chunk) < open_cnt &&
                    has_free(int'(active_chunk))) begin
                    r = pop_block(int'(active_chunk));
                    found = 1'b1;
                end
                for (int c = 0; c < open_cnt; c++) begin
                    if (!found && has_free(c)) begin
                        r = pop_block(c);
                        found = 1'b1;
                    end
                end
                if (!found && open_cnt < MAX_CHUNKS) begin
                    open_cnt++;
                    if (has_free(open_cnt - 1)) begin
                        r = pop_block(open_cnt - 1);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_OOM;
                end
            end else begin
                fc = int'(cmd.chunk);
                if (fc >= open_cnt || int'(cmd.block) >= BLOCKS_PER_CHUNK) begin
                    r.status = ST_BAD_FREE;
                end else begin
                    idx = int'(cmd.block) + 1;
                    link_mem[fc][idx] = list_head[fc];
                    list_head[fc] = COUNT_W'(idx);
                    if (int'(free_cnt[fc]) < BLOCKS_PER_CHUNK) begin
                        free_cnt[fc] = free_cnt[fc] + COUNT_W'(1);
                    end
                    // a wholly free chunk becomes the current one
                    if (int'(free_cnt[fc]) == BLOCKS_PER_CHUNK) begin
                        active_chunk = CHUNK_W'(fc);
                        cur_ok = 1'b1;
                    end
                    r.status = ST_FREED;
                    r.count = free_cnt[fc];
                end
            end
            pending_replies.push_back(r);
            return r;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_status st, logic [OUT_TDATA_W-1:0] data);
            t_result exp_r;
            if (pending_replies.size() == 0) begin
                $error("result with none expected: status %0d, tdata %h", st, data);
                mismatches++;
                return;
            end
            exp_r = pending_replies.pop_front();
            compare_field("status", 32'(exp_r.status), 32'(st));
            compare_field("alloc_chunk", 32'(exp_r.chunk), 32'(data[2:0]));
            compare_field("alloc_block", 32'(exp_r.block), 32'(data[10:3]));
            compare_field("byte_offset", 32'(exp_r.offset), 32'(data[34:11]));
            compare_field("chunk_free_count", 32'(exp_r.count), 32'(data[43:35]));
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // free_chunk, free_block
    logic                    s_axis_tuser;   // opcode
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // alloc_chunk, alloc_block, byte_offset, count
    logic [STATUS_W-1:0]     m_axis_tuser;   // status
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [BB_W-1:0]         i_cfg_data;

    pool_tracker             pool;
    logic [ADDR_W-1:0]       live_blocks [$];
    logic [ADDR_W-1:0]       last_freed;
    bit                      idling_on;
    int                      hold_requests;
    int                      hold_served;

    chunked_free_list_block_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pool.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // result side: ready stretches, short stalls, and long hold-offs on request
    initial begin
        m_axis_tready <= 1'b0;
        hold_served = 0;
        @(posedge i_clk);
        forever begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** chunked_free_list_block_allocator: FAILED **");
        $finish;
    end

    task automatic send_request(input t_cmd_kind kind, input logic [CHUNK_W-1:0] chunk,
                                input logic [BLOCK_W-1:0] block, output t_status st);
        t_cmd    cmd;
        t_result r;
        cmd.kind = kind;
        cmd.chunk = chunk;
        cmd.block = block;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'({block, chunk});
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = pool.note_request(cmd);
        st = r.status;
        if (r.status == ST_ALLOC) begin
            live_blocks.push_back({r.chunk, r.block});
        end
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= IN_TDATA_W'($urandom);
            s_axis_tuser <= 1'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic alloc_one(output t_status st);
        send_request(CMD_ALLOC, CHUNK_W'($urandom), BLOCK_W'($urandom), st);
    endtask

    task automatic free_one(input logic [CHUNK_W-1:0] chunk, input logic [BLOCK_W-1:0] block);
        t_status st;
        send_request(CMD_FREE, chunk, block, st);
    endtask

    task automatic free_live();
        int                idx;
        logic [ADDR_W-1:0] h;
        idx = $urandom_range(0, live_blocks.size() - 1);
        h = live_blocks[idx];
        live_blocks.delete(idx);
        last_freed = h;
        free_one(h[ADDR_W-1:BLOCK_W], h[BLOCK_W-1:0]);
    endtask

    // alloc_pct biases the pool toward growing or draining
    task automatic run_mix(input int count, input int alloc_pct, input int hold_at);
        int      roll;
        t_status st;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (i == hold_at) begin
                hold_requests++;
            end
            if (roll < alloc_pct || live_blocks.size() == 0) begin
                alloc_one(st);
            end else if (roll < 93) begin
                free_live();
            end else if (roll < 97) begin
                free_one(CHUNK_W'($urandom), BLOCK_W'($urandom));
            end else begin
                free_one(last_freed[ADDR_W-1:BLOCK_W], last_freed[BLOCK_W-1:0]);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_block_bytes(input logic [BB_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        pool.unit_bytes = value;
    endtask

    initial begin
        t_status st;
        pool = new();
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        idling_on = 1'b1;
        hold_requests = 0;
        last_freed = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset block size, invalid frees, double free, saturation
        free_one(3'd0, 8'd0);
        alloc_one(st);
        alloc_one(st);
        free_one(3'd0, 8'd1);
        free_one(3'd0, 8'd1);
        free_one(3'd0, 8'd0);
        free_one(3'd7, 8'd255);
        free_one(3'd1, 8'd0);
        alloc_one(st);
        alloc_one(st);
        alloc_one(st);
        free_one(3'd0, 8'd255);
        free_one(3'd0, 8'h55);
        free_one(3'd0, 8'haa);
        alloc_one(st);
        alloc_one(st);
        alloc_one(st);
        free_one(3'd5, 8'h80);

        set_block_bytes(BB_W'(1));
        run_mix(200, 75, 120);
        set_block_bytes(BB_W'(65536));
        run_mix(200, 55, 40);
        set_block_bytes(BB_W'($urandom_range(2, 65535)));
        run_mix(200, 30, -1);
        set_block_bytes(BB_W'($urandom_range(1, 65536)));
        run_mix(200, 60, 150);
        set_block_bytes(BB_W'(65535));

        // no idling from here: grow the pool into new chunks, then drain it
        idling_on = 1'b0;
        run_mix(250, 90, -1);
        run_mix(80, 10, -1);

        drain();
        repeat (8) @(posedge i_clk);
        if (pool.mismatches == 0) begin
            $display("** chunked_free_list_block_allocator: PASSED **");
        end else begin
            $display("** chunked_free_list_block_allocator: FAILED **");
        end
        $finish;
    end

endmodule
